// ===== hw/rtl/sfbs_pkg.sv =====
// Shared types and constants for the status frame byte stuffer.
// No dependencies; used by every module in hw/rtl.
package sfbs_pkg;

    // Sample width used when splitting joystick readings into bytes
    localparam int SAMPLE_BITS = 10;
    localparam int WIDE_BITS   = 16;
    localparam logic [WIDE_BITS-1:0] SAMPLE_MASK =
        WIDE_BITS'((32'd1 << SAMPLE_BITS) - 32'd1);

    // Configuration register indexes
    localparam logic [1:0] CFG_START   = 2'd0;
    localparam logic [1:0] CFG_DISPLAY = 2'd1;
    localparam logic [1:0] CFG_ESCAPE  = 2'd2;
    localparam logic [1:0] CFG_END     = 2'd3;

    // Marker reset values
    localparam logic [7:0] RST_START   = 8'd2;
    localparam logic [7:0] RST_DISPLAY = 8'd4;
    localparam logic [7:0] RST_ESCAPE  = 8'd27;
    localparam logic [7:0] RST_END     = 8'd3;

    // Frame positions of the sequencer
    localparam logic [3:0] POS_IDLE  = 4'd0;
    localparam logic [3:0] POS_START = 4'd1;
    localparam logic [3:0] POS_PAY0  = 4'd2;
    localparam logic [3:0] POS_PAY1  = 4'd3;
    localparam logic [3:0] POS_PAY2  = 4'd4;
    localparam logic [3:0] POS_PAY3  = 4'd5;
    localparam logic [3:0] POS_PAY4  = 4'd6;
    localparam logic [3:0] POS_PAY5  = 4'd7;
    localparam logic [3:0] POS_PAY6  = 4'd8;
    localparam logic [3:0] POS_PAY7  = 4'd9;
    localparam logic [3:0] POS_PAY8  = 4'd10;
    localparam logic [3:0] POS_PAY9  = 4'd11;
    localparam logic [3:0] POS_SUM   = 4'd12;
    localparam logic [3:0] POS_END   = 4'd13;

    typedef struct packed {
        logic [7:0] start_m;
        logic [7:0] display_m;
        logic [7:0] escape_m;
        logic [7:0] end_m;
    } t_markers;

    // One output word: frame byte plus last flag
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_beat;

    // Sequencer status seen by the top level
    typedef struct packed {
        logic       busy;
        logic       load_last;
        logic [3:0] pos;
        logic       reply_en;
    } t_seq_status;

endpackage

// ===== hw/rtl/sfbs_match.sv =====
// Shared marker compare unit: flags a byte that needs an escape prefix.
// Depends on sfbs_pkg.
module sfbs_match (
    input  logic [7:0]        i_byte,
    input  sfbs_pkg::t_markers i_markers,
    output logic              o_hit
);

    // Independent compares; equal markers still give a single hit
    assign o_hit = (i_byte == i_markers.start_m)   ||
                   (i_byte == i_markers.display_m) ||
                   (i_byte == i_markers.escape_m)  ||
                   (i_byte == i_markers.end_m);

endmodule

// ===== hw/rtl/sfbs_oreg.sv =====
// Output register stage: holds one frame word until the sink takes it.
// Depends on sfbs_pkg.
module sfbs_oreg (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_load,
    input  sfbs_pkg::t_beat i_beat,
    input  logic           i_stall,
    output logic           o_ready,
    output logic           o_valid,
    output logic [7:0]     o_frame_byte,
    output logic           o_frame_end
);

    logic           r_valid;
    sfbs_pkg::t_beat r_beat;

    // Room for a new word when empty or the held word leaves this edge
    assign o_ready = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_load) begin
            r_beat <= i_beat;
        end
    end

    assign o_valid      = r_valid;
    assign o_frame_byte = r_beat.data;
    assign o_frame_end  = r_beat.last;

endmodule

// ===== hw/rtl/sfbs_seq.sv =====
// Frame sequencer: latches a sample, walks the frame one word per step,
// drives the shared compare unit and keeps the running checksum.
// Depends on sfbs_pkg and sfbs_match.
module sfbs_seq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic [9:0]         i_joystick_x,
    input  logic [9:0]         i_joystick_y,
    input  logic               i_joystick_button,
    input  logic               i_first_button,
    input  logic               i_second_button,
    input  logic               i_reply_enable,
    input  logic [7:0]         i_reply_id,
    input  logic [7:0]         i_reply_ack,
    input  sfbs_pkg::t_markers  i_markers,
    input  logic               i_out_ready,
    output logic               o_load,
    output sfbs_pkg::t_beat     o_beat,
    output sfbs_pkg::t_seq_status o_status
);

    logic [3:0] r_pos, n_pos;
    logic       r_esc, n_esc;
    logic [7:0] r_sum, n_sum;

    // Latched sample (payload registers, no reset needed)
    logic [9:0] r_x, r_y;
    logic       r_jb, r_b1, r_b2, r_en;
    logic [7:0] r_id, r_ack;

    logic [sfbs_pkg::WIDE_BITS-1:0] x_wide, y_wide;
    logic [7:0] cur_byte;
    logic       stuffable;
    logic       is_payload;
    logic       hit;
    logic       busy;

    assign busy = (r_pos != sfbs_pkg::POS_IDLE);

    // Mask the samples to the configured sample width
    assign x_wide = sfbs_pkg::WIDE_BITS'(r_x) & sfbs_pkg::SAMPLE_MASK;
    assign y_wide = sfbs_pkg::WIDE_BITS'(r_y) & sfbs_pkg::SAMPLE_MASK;

    // Byte at the current frame position
    always_comb begin
        cur_byte   = 8'h00;
        stuffable  = 1'b1;
        is_payload = 1'b1;
        case (r_pos)
            sfbs_pkg::POS_START: begin
                cur_byte   = i_markers.start_m;
                stuffable  = 1'b0;
                is_payload = 1'b0;
            end
            sfbs_pkg::POS_PAY0: cur_byte = x_wide[15:8];
            sfbs_pkg::POS_PAY1: cur_byte = x_wide[7:0];
            sfbs_pkg::POS_PAY2: cur_byte = y_wide[15:8];
            sfbs_pkg::POS_PAY3: cur_byte = y_wide[7:0];
            sfbs_pkg::POS_PAY4: cur_byte = {7'd0, r_jb};
            sfbs_pkg::POS_PAY5: cur_byte = {7'd0, r_b1};
            sfbs_pkg::POS_PAY6: cur_byte = {7'd0, r_b2};
            sfbs_pkg::POS_PAY7: cur_byte = {7'd0, r_en};
            sfbs_pkg::POS_PAY8: cur_byte = r_id;
            sfbs_pkg::POS_PAY9: cur_byte = r_ack;
            sfbs_pkg::POS_SUM: begin
                cur_byte   = r_sum;
                is_payload = 1'b0;
            end
            sfbs_pkg::POS_END: begin
                cur_byte   = i_markers.end_m;
                stuffable  = 1'b0;
                is_payload = 1'b0;
            end
            default: begin
                stuffable  = 1'b0;
                is_payload = 1'b0;
            end
        endcase
    end

    sfbs_match u_match (
        .i_byte    (cur_byte),
        .i_markers (i_markers),
        .o_hit     (hit)
    );

    assign o_load = busy && i_out_ready;

    // Step control: escape word first, then the byte itself
    always_comb begin
        n_pos       = r_pos;
        n_esc       = r_esc;
        n_sum       = r_sum;
        o_beat.data = cur_byte;
        o_beat.last = (r_pos == sfbs_pkg::POS_END);
        if (i_accept) begin
            n_pos = sfbs_pkg::POS_START;
            n_esc = 1'b0;
            n_sum = 8'd0;
        end else if (o_load) begin
            if (stuffable && hit && !r_esc) begin
                o_beat.data = i_markers.escape_m;
                n_esc       = 1'b1;
            end else begin
                n_esc = 1'b0;
                if (is_payload) begin
                    n_sum = r_sum + cur_byte;
                end
                if (r_pos == sfbs_pkg::POS_END) begin
                    n_pos = sfbs_pkg::POS_IDLE;
                end else if (r_pos == sfbs_pkg::POS_PAY7 && !r_en) begin
                    n_pos = sfbs_pkg::POS_SUM;
                end else begin
                    n_pos = r_pos + 4'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= sfbs_pkg::POS_IDLE;
            r_esc <= 1'b0;
            r_sum <= 8'd0;
        end else begin
            r_pos <= n_pos;
            r_esc <= n_esc;
            r_sum <= n_sum;
        end
    end

    // Sample latch
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_x   <= i_joystick_x;
            r_y   <= i_joystick_y;
            r_jb  <= i_joystick_button;
            r_b1  <= i_first_button;
            r_b2  <= i_second_button;
            r_en  <= i_reply_enable;
            r_id  <= i_reply_id;
            r_ack <= i_reply_ack;
        end
    end

    assign o_status.busy      = busy;
    assign o_status.load_last = o_load && o_beat.last;
    assign o_status.pos       = r_pos;
    assign o_status.reply_en  = r_en;

endmodule

// ===== hw/rtl/status_frame_byte_stuffer.sv =====
// Status frame byte stuffer, top level: marker registers, sequencer, output stage.
// The first frame word passes the sequencer position register, then the output register.
// Throughput: one frame word per cycle while the sink does not stall; a frame holds 11 to 24
// words, and the sequencer takes a new sample only when idle, after the end word is handed over.
// Reset (synchronous, active low) idles the sequencer, empties the output
// stage and loads the marker registers with 2, 4, 27 and 3.
module status_frame_byte_stuffer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // sample channel
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [9:0] i_joystick_x,
    input  logic [9:0] i_joystick_y,
    input  logic       i_joystick_button,
    input  logic       i_first_button,
    input  logic       i_second_button,
    input  logic       i_reply_enable,
    input  logic [7:0] i_reply_id,
    input  logic [7:0] i_reply_ack,
    // frame channel
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_frame_byte,
    output logic       o_frame_end,
    // configuration
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [7:0] i_cfg_data
);

    sfbs_pkg::t_markers    r_markers;
    sfbs_pkg::t_beat       beat;
    sfbs_pkg::t_seq_status status;
    logic                  accept;
    logic                  load;
    logic                  out_ready;

    // Marker registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_markers.start_m   <= sfbs_pkg::RST_START;
            r_markers.display_m <= sfbs_pkg::RST_DISPLAY;
            r_markers.escape_m  <= sfbs_pkg::RST_ESCAPE;
            r_markers.end_m     <= sfbs_pkg::RST_END;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                sfbs_pkg::CFG_START:   r_markers.start_m   <= i_cfg_data;
                sfbs_pkg::CFG_DISPLAY: r_markers.display_m <= i_cfg_data;
                sfbs_pkg::CFG_ESCAPE:  r_markers.escape_m  <= i_cfg_data;
                sfbs_pkg::CFG_END:     r_markers.end_m     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_stall = status.busy;
    assign accept  = i_valid && !status.busy;

    sfbs_seq u_seq (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_accept          (accept),
        .i_joystick_x      (i_joystick_x),
        .i_joystick_y      (i_joystick_y),
        .i_joystick_button (i_joystick_button),
        .i_first_button    (i_first_button),
        .i_second_button   (i_second_button),
        .i_reply_enable    (i_reply_enable),
        .i_reply_id        (i_reply_id),
        .i_reply_ack       (i_reply_ack),
        .i_markers         (r_markers),
        .i_out_ready       (out_ready),
        .o_load            (load),
        .o_beat            (beat),
        .o_status          (status)
    );

    sfbs_oreg u_oreg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (load),
        .i_beat       (beat),
        .i_stall      (i_stall),
        .o_ready      (out_ready),
        .o_valid      (o_valid),
        .o_frame_byte (o_frame_byte),
        .o_frame_end  (o_frame_end)
    );

`ifndef SYNTHESIS
    // An accepted sample starts a frame at once
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (status.busy && status.pos == sfbs_pkg::POS_START))
        else $error("frame did not start after accept");

    // Handing over the end word returns the sequencer to idle
    a_end_idles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.load_last |=> !status.busy)
        else $error("sequencer busy after end word");

    // Reply bytes are skipped when the reply is disabled
    a_no_reply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (status.busy && !status.reply_en) |->
            (status.pos != sfbs_pkg::POS_PAY8 && status.pos != sfbs_pkg::POS_PAY9))
        else $error("reply bytes in a frame without reply");

    // Sequencer never runs past the end word
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.pos <= sfbs_pkg::POS_END)
        else $error("frame position out of range");
`endif

endmodule
